// File: src/hsvrgb_pkg.sv
package hsvrgb_pkg;

  // Fixed-point formats
  localparam int LEVEL_FRAC_BITS = 12;
  localparam int HUE_FRAC_BITS   = 4;

  localparam int IN_W    = 16;                    // width of every input field
  localparam int LVL_W   = LEVEL_FRAC_BITS + 1;   // 0 .. ONE inclusive
  localparam int OUT_W   = 13;                    // width of every output channel
  localparam int LVL_ONE = 1 << LEVEL_FRAC_BITS;

  localparam int HUE_TURN   = 360 << HUE_FRAC_BITS;
  localparam int HUE_SECTOR = 60 << HUE_FRAC_BITS;

  // Whole turns added so that the most negative hue becomes non-negative
  localparam int HUE_OFFSET = ((32768 + HUE_TURN - 1) / HUE_TURN) * HUE_TURN;
  localparam int HPOS_MAX   = 32767 + HUE_OFFSET;
  localparam int HPOS_W     = $clog2(HPOS_MAX + 1);
  localparam int HQ_W       = $clog2(HPOS_MAX / HUE_TURN + 1);
  localparam int HUE_W      = $clog2(HUE_TURN);

  // Turn count by reciprocal; floor reciprocal, estimate low by at most one
  localparam int TURN_SHIFT = 24;
  localparam int TURN_RECIP = (1 << TURN_SHIFT) / HUE_TURN;
  localparam int TRECIP_W   = $clog2(TURN_RECIP + 1);
  localparam int TPROD_W    = (HPOS_W + TRECIP_W > TURN_SHIFT + HQ_W) ?
                              HPOS_W + TRECIP_W : TURN_SHIFT + HQ_W;

  // Position inside a sector, mirrored for odd sectors: 0 .. SECTOR inclusive
  localparam int RES_W  = $clog2(HUE_SECTOR + 1);
  localparam int PROD_W = LVL_W + RES_W;

  // Exact floor division by the sector width: ceiling reciprocal
  localparam int    SEC_SHIFT = 32;
  localparam longint SEC_RECIP =
    ((longint'(1) << SEC_SHIFT) + longint'(HUE_SECTOR) - 1) / longint'(HUE_SECTOR);
  localparam int    SRECIP_W  = $clog2(SEC_RECIP + 1);
  localparam int    SPROD_W   = (PROD_W + SRECIP_W > SEC_SHIFT + LVL_W) ?
                                PROD_W + SRECIP_W : SEC_SHIFT + LVL_W;

  // Input to result latency in clock cycles
  localparam int LATENCY = 6;

endpackage

// File: src/hsv_hsl_to_rgb.sv
// HSV / HSL to RGB pixel converter. A pixel is taken at every rising edge with start high
// (busy is tied low, so one pixel per clock is sustained indefinitely) and its red, green
// and blue appear at the end of the pipeline for one cycle, flagged by
// result_valid_o. The receiver cannot stall the block, so results must be taken as they
// come. The six-stage pipeline sets both the latency and the one-pixel-per-clock rate:
// input clamp and turn estimate, chroma multiply and hue wrap, sector decode and offset,
// chroma-by-position multiply, reciprocal divide by the sector width, channel assembly.
// Hue is in sixteenths of a degree, signed and wrapped; saturation and value/lightness use
// 4096 as 1.0 and are clamped. The colour model (0 HSV, 1 HSL) is a one-bit register
// written through the cfg channel, which is always ready; change it only while no pixel
// is in flight.
module hsv_hsl_to_rgb (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel command
  input  logic                            start,
  output logic                            busy,
  input  logic signed [hsvrgb_pkg::IN_W-1:0] hue_in_i,
  input  logic signed [hsvrgb_pkg::IN_W-1:0] sat_in_i,
  input  logic signed [hsvrgb_pkg::IN_W-1:0] level_in_i,
  // result strobe
  output logic                            result_valid_o,
  output logic [hsvrgb_pkg::OUT_W-1:0]    red_out_o,
  output logic [hsvrgb_pkg::OUT_W-1:0]    green_out_o,
  output logic [hsvrgb_pkg::OUT_W-1:0]    blue_out_o,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_data_i
);

  localparam int LVL_W  = hsvrgb_pkg::LVL_W;
  localparam int HPOS_W = hsvrgb_pkg::HPOS_W;
  localparam int HQ_W   = hsvrgb_pkg::HQ_W;
  localparam int HUE_W  = hsvrgb_pkg::HUE_W;
  localparam int RES_W  = hsvrgb_pkg::RES_W;
  localparam int PROD_W = hsvrgb_pkg::PROD_W;
  localparam int OUT_W  = hsvrgb_pkg::OUT_W;
  localparam int NSTG   = hsvrgb_pkg::LATENCY;

  // Hue sectors, named by the dominant and rising/falling channel
  typedef enum logic [2:0] {
    SEC_RED_UP_G  = 3'd0,
    SEC_GRN_DN_R  = 3'd1,
    SEC_GRN_UP_B  = 3'd2,
    SEC_BLU_DN_G  = 3'd3,
    SEC_BLU_UP_R  = 3'd4,
    SEC_RED_DN_B  = 3'd5
  } sector_e;

  logic            accept;
  logic            mdl_q;
  logic [NSTG-1:0] vld_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  // Colour model register; a transfer updates it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mdl_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mdl_q <= cfg_data_i;
    end
  end

  // Valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], accept};
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 1: clamp, HSL lightness fold, hue made positive and whole turns estimated
  // ---------------------------------------------------------------------------------------
  logic [LVL_W-1:0]  sat_cl, lvl_cl, fold, base_d;
  logic [LVL_W:0]    lvl_x2;
  logic [HPOS_W-1:0] hpos_d;
  logic [hsvrgb_pkg::TPROD_W-1:0] turn_prod;

  logic [HPOS_W-1:0] s1_hpos_q;
  logic [HQ_W-1:0]   s1_hq_q;
  logic [LVL_W-1:0]  s1_base_q, s1_sat_q, s1_lvl_q;
  logic              s1_mdl_q;

  always_comb begin
    if (sat_in_i[hsvrgb_pkg::IN_W-1]) begin
      sat_cl = '0;
    end else if ({1'b0, sat_in_i} > (hsvrgb_pkg::IN_W+1)'(hsvrgb_pkg::LVL_ONE)) begin
      sat_cl = LVL_W'(hsvrgb_pkg::LVL_ONE);
    end else begin
      sat_cl = LVL_W'(sat_in_i);
    end

    if (level_in_i[hsvrgb_pkg::IN_W-1]) begin
      lvl_cl = '0;
    end else if ({1'b0, level_in_i} > (hsvrgb_pkg::IN_W+1)'(hsvrgb_pkg::LVL_ONE)) begin
      lvl_cl = LVL_W'(hsvrgb_pkg::LVL_ONE);
    end else begin
      lvl_cl = LVL_W'(level_in_i);
    end

    // ONE - |2L - ONE|
    lvl_x2 = {lvl_cl, 1'b0};
    if (lvl_x2 >= (LVL_W+1)'(hsvrgb_pkg::LVL_ONE)) begin
      fold = LVL_W'((LVL_W+1)'(2 * hsvrgb_pkg::LVL_ONE) - lvl_x2);
    end else begin
      fold = LVL_W'(lvl_x2);
    end
    base_d = mdl_q ? fold : lvl_cl;

    hpos_d    = HPOS_W'(int'(hue_in_i) + hsvrgb_pkg::HUE_OFFSET);
    turn_prod = hsvrgb_pkg::TPROD_W'(hpos_d)
              * hsvrgb_pkg::TPROD_W'(hsvrgb_pkg::TURN_RECIP);
  end

  always_ff @(posedge clk_i) begin
    s1_hpos_q <= hpos_d;
    s1_hq_q   <= turn_prod[hsvrgb_pkg::TURN_SHIFT +: HQ_W];
    s1_base_q <= base_d;
    s1_sat_q  <= sat_cl;
    s1_lvl_q  <= lvl_cl;
    s1_mdl_q  <= mdl_q;
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: chroma product, hue wrapped into one turn (estimate may be one turn short)
  // ---------------------------------------------------------------------------------------
  logic [2*LVL_W-1:0] chroma_prod;
  logic [HPOS_W-1:0]  hue_raw;
  logic [HUE_W-1:0]   hue_d;

  logic [HUE_W-1:0] s2_hue_q;
  logic [LVL_W-1:0] s2_chroma_q, s2_lvl_q;
  logic             s2_mdl_q;

  always_comb begin
    chroma_prod = (2*LVL_W)'(s1_base_q) * (2*LVL_W)'(s1_sat_q);
    hue_raw     = s1_hpos_q - HPOS_W'(int'(s1_hq_q) * hsvrgb_pkg::HUE_TURN);
    if (int'(hue_raw) >= hsvrgb_pkg::HUE_TURN) begin
      hue_d = HUE_W'(hue_raw - HPOS_W'(hsvrgb_pkg::HUE_TURN));
    end else begin
      hue_d = HUE_W'(hue_raw);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_hue_q    <= hue_d;
    s2_chroma_q <= chroma_prod[hsvrgb_pkg::LEVEL_FRAC_BITS +: LVL_W];
    s2_lvl_q    <= s1_lvl_q;
    s2_mdl_q    <= s1_mdl_q;
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: sector, position in sector (mirrored when odd), offset m
  // ---------------------------------------------------------------------------------------
  logic [2:0]       sec_cnt;
  logic [RES_W-1:0] rem, frac_d;
  logic [LVL_W-1:0] off_d;

  logic [RES_W-1:0] s3_frac_q;
  logic [LVL_W-1:0] s3_chroma_q, s3_off_q;
  sector_e          s3_sec_q;

  always_comb begin
    sec_cnt = '0;
    for (int j = 1; j < 6; j++) begin
      if (int'(s2_hue_q) >= j * hsvrgb_pkg::HUE_SECTOR) begin
        sec_cnt = sec_cnt + 3'd1;
      end
    end
    rem = RES_W'(int'(s2_hue_q) - int'(sec_cnt) * hsvrgb_pkg::HUE_SECTOR);
    if (sec_cnt[0]) begin
      frac_d = RES_W'(hsvrgb_pkg::HUE_SECTOR) - rem;
    end else begin
      frac_d = rem;
    end
    if (s2_mdl_q) begin
      off_d = s2_lvl_q - (s2_chroma_q >> 1);
    end else begin
      off_d = s2_lvl_q - s2_chroma_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_sec_q    <= sector_e'(sec_cnt);
    s3_frac_q   <= frac_d;
    s3_chroma_q <= s2_chroma_q;
    s3_off_q    <= off_d;
  end

  // ---------------------------------------------------------------------------------------
  // Stage 4: C times position
  // ---------------------------------------------------------------------------------------
  logic [PROD_W-1:0] s4_prod_q;
  logic [LVL_W-1:0]  s4_chroma_q, s4_off_q;
  sector_e           s4_sec_q;

  always_ff @(posedge clk_i) begin
    s4_prod_q   <= PROD_W'(s3_chroma_q) * PROD_W'(s3_frac_q);
    s4_chroma_q <= s3_chroma_q;
    s4_off_q    <= s3_off_q;
    s4_sec_q    <= s3_sec_q;
  end

  // ---------------------------------------------------------------------------------------
  // Stage 5: X = product / sector width, by exact reciprocal multiply
  // ---------------------------------------------------------------------------------------
  logic [hsvrgb_pkg::SPROD_W-1:0] sec_prod;

  logic [LVL_W-1:0] s5_x_q, s5_chroma_q, s5_off_q;
  sector_e          s5_sec_q;

  assign sec_prod = hsvrgb_pkg::SPROD_W'(s4_prod_q)
                  * hsvrgb_pkg::SPROD_W'(hsvrgb_pkg::SEC_RECIP);

  always_ff @(posedge clk_i) begin
    s5_x_q      <= sec_prod[hsvrgb_pkg::SEC_SHIFT +: LVL_W];
    s5_chroma_q <= s4_chroma_q;
    s5_off_q    <= s4_off_q;
    s5_sec_q    <= s4_sec_q;
  end

  // ---------------------------------------------------------------------------------------
  // Stage 6: place C and X by sector, add m, output register
  // ---------------------------------------------------------------------------------------
  logic [LVL_W-1:0] red_c, grn_c, blu_c;

  always_comb begin
    red_c = '0;
    grn_c = '0;
    blu_c = '0;
    case (s5_sec_q)
      SEC_RED_UP_G: begin
        red_c = s5_chroma_q;
        grn_c = s5_x_q;
      end
      SEC_GRN_DN_R: begin
        red_c = s5_x_q;
        grn_c = s5_chroma_q;
      end
      SEC_GRN_UP_B: begin
        grn_c = s5_chroma_q;
        blu_c = s5_x_q;
      end
      SEC_BLU_DN_G: begin
        grn_c = s5_x_q;
        blu_c = s5_chroma_q;
      end
      SEC_BLU_UP_R: begin
        red_c = s5_x_q;
        blu_c = s5_chroma_q;
      end
      default: begin
        red_c = s5_chroma_q;
        blu_c = s5_x_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    red_out_o   <= OUT_W'(red_c + s5_off_q);
    green_out_o <= OUT_W'(grn_c + s5_off_q);
    blue_out_o  <= OUT_W'(blu_c + s5_off_q);
  end

  assign result_valid_o = vld_q[NSTG-1];

endmodule

// File: src/hsvrgb_chk.sv
module hsvrgb_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               start,
  input logic                               busy,
  input logic signed [hsvrgb_pkg::IN_W-1:0] sat_in_i,
  input logic                               result_valid_o,
  input logic [hsvrgb_pkg::OUT_W-1:0]       red_out_o,
  input logic [hsvrgb_pkg::OUT_W-1:0]       green_out_o,
  input logic [hsvrgb_pkg::OUT_W-1:0]       blue_out_o
);

  localparam int LAT = hsvrgb_pkg::LATENCY;

  // Every accepted pixel yields a result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LAT result_valid_o)
    else $error("result missing after accepted pixel");

  // No result without a pixel taken the fixed latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LAT))
    else $error("result without matching pixel");

  // Channels never exceed full scale
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (red_out_o <= hsvrgb_pkg::OUT_W'(hsvrgb_pkg::LVL_ONE)) &&
                       (green_out_o <= hsvrgb_pkg::OUT_W'(hsvrgb_pkg::LVL_ONE)) &&
                       (blue_out_o <= hsvrgb_pkg::OUT_W'(hsvrgb_pkg::LVL_ONE)))
    else $error("channel above full scale");

  // Zero saturation gives grey
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(start && !busy && (sat_in_i[hsvrgb_pkg::IN_W-1] ||
                                                sat_in_i == '0), LAT)
    |-> (red_out_o == green_out_o) && (green_out_o == blue_out_o))
    else $error("unsaturated pixel not grey");

endmodule

bind hsv_hsl_to_rgb hsvrgb_chk u_hsvrgb_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .sat_in_i       (sat_in_i),
  .result_valid_o (result_valid_o),
  .red_out_o      (red_out_o),
  .green_out_o    (green_out_o),
  .blue_out_o     (blue_out_o)
);
